/* design/wifi_qr_payload_parser_core_macros.svh */
// ----------------------------------------------------------------------------
// wifi qr payload parser assertion macros
// concurrent checks used by the parser core, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef WIFI_QR_PAYLOAD_PARSER_CORE_MACROS_SVH
`define WIFI_QR_PAYLOAD_PARSER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition implies consequence in the same cycle
`define WQP_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the following cycle
`define WQP_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`else

`define WQP_ASSERT_SAME(label, clk, rst, cond, cons, msg)
`define WQP_ASSERT_NEXT(label, clk, rst, cond, cons, msg)

`endif

`endif

/* design/wqp_pkg.sv */
// ----------------------------------------------------------------------------
// wqp_pkg
// shared types, codes and keyword tables of the wifi qr payload parser
// ----------------------------------------------------------------------------
`default_nettype none

package wqp_pkg;

  localparam int SSID_MAX_DEFAULT    = 32;
  localparam int PASS_MAX_DEFAULT    = 64;
  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int KEYWORD_MAX         = 6;
  localparam int PREFIX_LEN          = 5;
  localparam int KW_COUNT            = 5;

  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_H      = 8'h48;

  localparam logic [1:0] KIND_SSID    = 2'd0;
  localparam logic [1:0] KIND_PASS    = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [1:0] SEC_OPEN = 2'd0;
  localparam logic [1:0] SEC_WEP  = 2'd1;
  localparam logic [1:0] SEC_WPA  = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_WIFI    = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE    = 3'd2;
  localparam logic [2:0] ST_BAD_HIDDEN  = 3'd3;
  localparam logic [2:0] ST_UNKNOWN_TAG = 3'd4;
  localparam logic [2:0] ST_TOO_LONG    = 3'd5;
  localparam logic [2:0] ST_TRUNCATED   = 3'd6;

  // keyword slots: 0 WPA, 1 WEP, 2 nopass, 3 true, 4 false
  localparam logic [2:0] KW_WPA    = 3'd0;
  localparam logic [2:0] KW_WEP    = 3'd1;
  localparam logic [2:0] KW_NOPASS = 3'd2;
  localparam logic [2:0] KW_TRUE   = 3'd3;
  localparam logic [2:0] KW_FALSE  = 3'd4;

  localparam logic [KW_COUNT-1:0] KW_ALL        = '1;
  localparam logic [KW_COUNT-1:0] KW_TYPE_GROUP = 5'b00111;
  localparam logic [KW_COUNT-1:0] KW_HID_GROUP  = 5'b11000;

  localparam logic [0:PREFIX_LEN-1][7:0] PREFIX_TEXT = "WIFI:";

  localparam logic [0:KW_COUNT-1][0:KEYWORD_MAX-1][7:0] KW_TEXT =
    {"WPA", 24'h0, "WEP", 24'h0, "nopass", "true", 16'h0, "false", 8'h0};

  localparam logic [0:KW_COUNT-1][6:0] KW_LEN = {7'd3, 7'd3, 7'd6, 7'd4, 7'd5};

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_TAG,
    PH_COLON,
    PH_VALUE,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    TAG_S,
    TAG_T,
    TAG_P,
    TAG_H
  } tag_t;

  // one classified payload byte as it sits in the queue
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_semi;
    logic       is_bslash;
    logic       is_colon;
    logic       tag_ok;
    tag_t       tag;
  } class_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic [1:0] record_kind;
    logic [7:0] char_value;
    logic [5:0] char_pos;
    logic [1:0] security_kind;
    logic       hidden_net;
    logic [5:0] ssid_count;
    logic [6:0] pass_count;
    logic [2:0] status_code;
    logic       run_end;
  } result_t;

  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (pos < 3'(KEYWORD_MAX) && k < 3'(KW_COUNT)) begin
      ch = KW_TEXT[k][pos];
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

/* design/wqp_classify.sv */
// ----------------------------------------------------------------------------
// wqp_classify
// front end decode of one payload byte into the flags the parser needs
// ----------------------------------------------------------------------------
`default_nettype none

module wqp_classify (
  input  wire logic [7:0]     data_byte,
  input  wire logic           last_byte,
  output wqp_pkg::class_t     item
);

  always_comb begin
    item           = '0;
    item.data      = data_byte;
    item.last      = last_byte;
    item.is_semi   = (data_byte == wqp_pkg::CH_SEMI);
    item.is_bslash = (data_byte == wqp_pkg::CH_BSLASH);
    item.is_colon  = (data_byte == wqp_pkg::CH_COLON);
    item.tag_ok    = 1'b1;
    case (data_byte)
      wqp_pkg::CH_S: item.tag = wqp_pkg::TAG_S;
      wqp_pkg::CH_T: item.tag = wqp_pkg::TAG_T;
      wqp_pkg::CH_P: item.tag = wqp_pkg::TAG_P;
      wqp_pkg::CH_H: item.tag = wqp_pkg::TAG_H;
      default: begin
        item.tag    = wqp_pkg::TAG_S;
        item.tag_ok = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/wqp_fifo.sv */
// ----------------------------------------------------------------------------
// wqp_fifo
// short queue of classified bytes between the front end and the parser
// ----------------------------------------------------------------------------
`default_nettype none

module wqp_fifo #(
  parameter int DEPTH = wqp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire wqp_pkg::class_t  push_item,
  input  wire logic             pop,
  output wqp_pkg::class_t       head,
  output wqp_pkg::fifo_stat_t   stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wqp_pkg::class_t mem [DEPTH];

  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CW'(1);
    end else if (pop && !push) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  assign head       = mem[rd_ptr];
  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);

endmodule

`default_nettype wire

/* design/wqp_engine.sv */
// ----------------------------------------------------------------------------
// wqp_engine
// back end parser: prefix check, tag fields, unescaping and the summary record
// ----------------------------------------------------------------------------
`default_nettype none

module wqp_engine #(
  parameter int SSID_MAX = wqp_pkg::SSID_MAX_DEFAULT,
  parameter int PASS_MAX = wqp_pkg::PASS_MAX_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire wqp_pkg::class_t  item,
  input  wire logic             item_avail,
  output logic                  pop,
  output logic                  record_valid,
  input  wire logic             record_stall,
  output wqp_pkg::result_t      record
);

  wqp_pkg::phase_t phase, phase_next;
  wqp_pkg::tag_t   current_tag, current_tag_next;
  logic [2:0]      prefix_pos, prefix_pos_next;
  logic            escape_pending, escape_pending_next;
  logic [6:0]      value_pos, value_pos_next;
  logic [wqp_pkg::KW_COUNT-1:0] candidates, candidates_next;
  logic [1:0]      security_reg, security_reg_next;
  logic            hidden_reg, hidden_reg_next;
  logic [5:0]      ssid_len_reg, ssid_len_reg_next;
  logic [6:0]      pass_len_reg, pass_len_reg_next;
  logic [2:0]      error_reg, error_reg_next;

  wqp_pkg::result_t res_next;
  logic             res_valid;

  // shared decode of the current byte against the state
  logic                         sp_tag;
  logic                         emit_char;
  logic                         over_lim;
  logic                         prefix_hit;
  logic [wqp_pkg::KW_COUNT-1:0] kw_group;
  logic [wqp_pkg::KW_COUNT-1:0] kw_hit;
  logic [wqp_pkg::KW_COUNT-1:0] kw_miss;
  logic [2:0]                   close_err;
  logic [1:0]                   sec_close;
  logic                         hid_close;
  logic                         sum_close;
  logic [2:0]                   sum_status;

  assign pop = item_avail && (!record_valid || !record_stall);

  always_comb begin
    sp_tag     = (current_tag == wqp_pkg::TAG_S) || (current_tag == wqp_pkg::TAG_P);
    emit_char  = escape_pending || (!item.is_bslash && !item.is_semi);
    over_lim   = (current_tag == wqp_pkg::TAG_S) ? (value_pos >= 7'(SSID_MAX))
                                                 : (value_pos >= 7'(PASS_MAX));
    prefix_hit = (prefix_pos < 3'(wqp_pkg::PREFIX_LEN)) &&
                 (item.data == wqp_pkg::PREFIX_TEXT[prefix_pos]);
    kw_group   = (current_tag == wqp_pkg::TAG_T) ? wqp_pkg::KW_TYPE_GROUP
                                                 : wqp_pkg::KW_HID_GROUP;
    for (int k = 0; k < wqp_pkg::KW_COUNT; k++) begin
      kw_hit[k]  = kw_group[k] && candidates[k] && (value_pos == wqp_pkg::KW_LEN[k]);
      kw_miss[k] = (value_pos >= wqp_pkg::KW_LEN[k]) ||
                   (wqp_pkg::kw_char(3'(k), value_pos[2:0]) != item.data);
    end
    close_err = wqp_pkg::ST_OK;
    if (!sp_tag && kw_hit == '0) begin
      close_err = (current_tag == wqp_pkg::TAG_T) ? wqp_pkg::ST_BAD_TYPE
                                                  : wqp_pkg::ST_BAD_HIDDEN;
    end
    sec_close = security_reg;
    if (kw_hit[wqp_pkg::KW_WPA]) begin
      sec_close = wqp_pkg::SEC_WPA;
    end else if (kw_hit[wqp_pkg::KW_WEP]) begin
      sec_close = wqp_pkg::SEC_WEP;
    end else if (kw_hit[wqp_pkg::KW_NOPASS]) begin
      sec_close = wqp_pkg::SEC_OPEN;
    end
    hid_close = hidden_reg;
    if (kw_hit[wqp_pkg::KW_TRUE]) begin
      hid_close = 1'b1;
    end else if (kw_hit[wqp_pkg::KW_FALSE]) begin
      hid_close = 1'b0;
    end
    // summary on a final byte
    sum_close = 1'b0;
    if (error_reg != wqp_pkg::ST_OK) begin
      sum_status = error_reg;
    end else if (phase == wqp_pkg::PH_PREFIX) begin
      sum_status = wqp_pkg::ST_NOT_WIFI;
    end else if (!item.is_semi) begin
      sum_status = wqp_pkg::ST_TRUNCATED;
    end else if (phase == wqp_pkg::PH_TAG) begin
      sum_status = wqp_pkg::ST_OK;
    end else if (phase == wqp_pkg::PH_VALUE && !escape_pending) begin
      sum_status = close_err;
      sum_close  = 1'b1;
    end else begin
      sum_status = wqp_pkg::ST_TRUNCATED;
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (item.last) begin
      phase_next = wqp_pkg::PH_PREFIX;
    end else begin
      case (phase)
        wqp_pkg::PH_PREFIX: begin
          if (!prefix_hit) begin
            phase_next = wqp_pkg::PH_ERROR;
          end else if (prefix_pos == 3'(wqp_pkg::PREFIX_LEN - 1)) begin
            phase_next = wqp_pkg::PH_TAG;
          end
        end
        wqp_pkg::PH_TAG: begin
          phase_next = item.tag_ok ? wqp_pkg::PH_COLON : wqp_pkg::PH_ERROR;
        end
        wqp_pkg::PH_COLON: begin
          phase_next = item.is_colon ? wqp_pkg::PH_VALUE : wqp_pkg::PH_ERROR;
        end
        wqp_pkg::PH_VALUE: begin
          if (sp_tag) begin
            if (emit_char && over_lim) begin
              phase_next = wqp_pkg::PH_ERROR;
            end else if (!escape_pending && item.is_semi) begin
              phase_next = wqp_pkg::PH_TAG;
            end
          end else if (item.is_semi) begin
            phase_next = (close_err != wqp_pkg::ST_OK) ? wqp_pkg::PH_ERROR
                                                       : wqp_pkg::PH_TAG;
          end
        end
        default: phase_next = wqp_pkg::PH_ERROR;
      endcase
    end
  end

  // datapath state and result
  always_comb begin
    current_tag_next    = current_tag;
    prefix_pos_next     = prefix_pos;
    escape_pending_next = escape_pending;
    value_pos_next      = value_pos;
    candidates_next     = candidates;
    security_reg_next   = security_reg;
    hidden_reg_next     = hidden_reg;
    ssid_len_reg_next   = ssid_len_reg;
    pass_len_reg_next   = pass_len_reg;
    error_reg_next      = error_reg;
    res_next            = '0;
    res_valid           = 1'b0;

    if (item.last) begin
      res_valid              = 1'b1;
      res_next.record_kind   = wqp_pkg::KIND_SUMMARY;
      res_next.security_kind = security_reg;
      res_next.hidden_net    = hidden_reg;
      res_next.ssid_count    = ssid_len_reg;
      res_next.pass_count    = pass_len_reg;
      res_next.status_code   = sum_status;
      res_next.run_end       = 1'b1;
      if (sum_close) begin
        case (current_tag)
          wqp_pkg::TAG_S: res_next.ssid_count = value_pos[5:0];
          wqp_pkg::TAG_P: res_next.pass_count = value_pos;
          wqp_pkg::TAG_T: res_next.security_kind = sec_close;
          wqp_pkg::TAG_H: res_next.hidden_net = hid_close;
          default: res_next.hidden_net = hidden_reg;
        endcase
      end
      current_tag_next    = wqp_pkg::TAG_S;
      prefix_pos_next     = '0;
      escape_pending_next = 1'b0;
      value_pos_next      = '0;
      candidates_next     = wqp_pkg::KW_ALL;
      security_reg_next   = wqp_pkg::SEC_OPEN;
      hidden_reg_next     = 1'b0;
      ssid_len_reg_next   = '0;
      pass_len_reg_next   = '0;
      error_reg_next      = wqp_pkg::ST_OK;
    end else begin
      case (phase)
        wqp_pkg::PH_PREFIX: begin
          if (prefix_hit) begin
            prefix_pos_next = prefix_pos + 3'd1;
          end else if (error_reg == wqp_pkg::ST_OK) begin
            error_reg_next = wqp_pkg::ST_NOT_WIFI;
          end
        end
        wqp_pkg::PH_TAG: begin
          if (item.tag_ok) begin
            current_tag_next = item.tag;
          end else if (error_reg == wqp_pkg::ST_OK) begin
            error_reg_next = wqp_pkg::ST_UNKNOWN_TAG;
          end
        end
        wqp_pkg::PH_COLON: begin
          if (item.is_colon) begin
            value_pos_next      = '0;
            escape_pending_next = 1'b0;
            candidates_next     = wqp_pkg::KW_ALL;
          end else if (error_reg == wqp_pkg::ST_OK) begin
            error_reg_next = wqp_pkg::ST_UNKNOWN_TAG;
          end
        end
        wqp_pkg::PH_VALUE: begin
          if (sp_tag) begin
            if (escape_pending) begin
              escape_pending_next = 1'b0;
            end else if (item.is_bslash) begin
              escape_pending_next = 1'b1;
            end else if (item.is_semi) begin
              if (current_tag == wqp_pkg::TAG_S) begin
                ssid_len_reg_next = value_pos[5:0];
              end else begin
                pass_len_reg_next = value_pos;
              end
            end
            if (emit_char) begin
              if (over_lim) begin
                if (error_reg == wqp_pkg::ST_OK) begin
                  error_reg_next = wqp_pkg::ST_TOO_LONG;
                end
              end else begin
                res_valid            = 1'b1;
                res_next.record_kind = (current_tag == wqp_pkg::TAG_S) ? wqp_pkg::KIND_SSID
                                                                       : wqp_pkg::KIND_PASS;
                res_next.char_value  = item.data;
                res_next.char_pos    = value_pos[5:0];
                value_pos_next       = value_pos + 7'd1;
              end
            end
          end else if (item.is_semi) begin
            if (close_err != wqp_pkg::ST_OK) begin
              if (error_reg == wqp_pkg::ST_OK) begin
                error_reg_next = close_err;
              end
            end else begin
              security_reg_next = sec_close;
              hidden_reg_next   = hid_close;
            end
          end else begin
            candidates_next = candidates & ~kw_miss;
            if (value_pos <= 7'(wqp_pkg::KEYWORD_MAX)) begin
              value_pos_next = value_pos + 7'd1;
            end
          end
        end
        default: begin
          error_reg_next = error_reg;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= wqp_pkg::PH_PREFIX;
      current_tag    <= wqp_pkg::TAG_S;
      prefix_pos     <= '0;
      escape_pending <= 1'b0;
      value_pos      <= '0;
      candidates     <= wqp_pkg::KW_ALL;
      security_reg   <= wqp_pkg::SEC_OPEN;
      hidden_reg     <= 1'b0;
      ssid_len_reg   <= '0;
      pass_len_reg   <= '0;
      error_reg      <= wqp_pkg::ST_OK;
      record_valid   <= 1'b0;
    end else if (pop) begin
      phase          <= phase_next;
      current_tag    <= current_tag_next;
      prefix_pos     <= prefix_pos_next;
      escape_pending <= escape_pending_next;
      value_pos      <= value_pos_next;
      candidates     <= candidates_next;
      security_reg   <= security_reg_next;
      hidden_reg     <= hidden_reg_next;
      ssid_len_reg   <= ssid_len_reg_next;
      pass_len_reg   <= pass_len_reg_next;
      error_reg      <= error_reg_next;
      record_valid   <= res_valid;
    end else if (!record_stall) begin
      record_valid <= 1'b0;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (pop) begin
      record <= res_next;
    end
  end

endmodule

`default_nettype wire

/* design/wifi_qr_payload_parser_core.sv */
// ----------------------------------------------------------------------------
// wifi_qr_payload_parser_core
// streaming parser for wifi qr code payloads, one byte per transfer
// ----------------------------------------------------------------------------
// Takes one payload byte per cycle while byte_stall is low, and gives at most
// one record per byte: an ssid or password character with its position, or the
// summary on the last byte. A byte is decoded on entry and written into a short
// queue (QUEUE_DEPTH entries); while the queue is not empty and no record is
// held by record_stall, the parser pulls one byte a cycle from the queue into
// its output register, so a record is offered on the cycle after its byte is
// taken. The single-step parser state update sets that rate; the queue absorbs
// bytes while a record waits on record_stall, and byte_stall rises only when
// the queue is full. No clearing pass is needed after reset.
`default_nettype none

`include "wifi_qr_payload_parser_core_macros.svh"

module wifi_qr_payload_parser_core #(
  parameter int SSID_MAX    = wqp_pkg::SSID_MAX_DEFAULT,
  parameter int PASS_MAX    = wqp_pkg::PASS_MAX_DEFAULT,
  parameter int QUEUE_DEPTH = wqp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output logic            record_valid,
  input  wire logic       record_stall,
  output logic [1:0]      record_kind,
  output logic [7:0]      char_value,
  output logic [5:0]      char_pos,
  output logic [1:0]      security_kind,
  output logic            hidden_net,
  output logic [5:0]      ssid_count,
  output logic [6:0]      pass_count,
  output logic [2:0]      status_code,
  output logic            run_end
);

  wqp_pkg::class_t     in_item;
  wqp_pkg::class_t     head_item;
  wqp_pkg::fifo_stat_t qstat;
  wqp_pkg::result_t    record;
  logic                push;
  logic                pop;

  wqp_classify u_classify (
    .data_byte (data_byte),
    .last_byte (last_byte),
    .item      (in_item)
  );

  assign byte_stall = qstat.full;
  assign push       = byte_valid && !qstat.full;

  wqp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (in_item),
    .pop       (pop),
    .head      (head_item),
    .stat      (qstat)
  );

  wqp_engine #(
    .SSID_MAX (SSID_MAX),
    .PASS_MAX (PASS_MAX)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .item         (head_item),
    .item_avail   (!qstat.empty),
    .pop          (pop),
    .record_valid (record_valid),
    .record_stall (record_stall),
    .record       (record)
  );

  assign record_kind   = record.record_kind;
  assign char_value    = record.char_value;
  assign char_pos      = record.char_pos;
  assign security_kind = record.security_kind;
  assign hidden_net    = record.hidden_net;
  assign ssid_count    = record.ssid_count;
  assign pass_count    = record.pass_count;
  assign status_code   = record.status_code;
  assign run_end       = record.run_end;

  `WQP_ASSERT_SAME(a_queue_flags, clk, rst, 1'b1,
                   !(qstat.full && qstat.empty), "queue full and empty")
  `WQP_ASSERT_SAME(a_pop_nonempty, clk, rst, pop, !qstat.empty, "pop from empty queue")
  `WQP_ASSERT_SAME(a_run_end_kind, clk, rst, record_valid,
                   run_end == (record_kind == wqp_pkg::KIND_SUMMARY), "run_end mismatch")
  `WQP_ASSERT_SAME(a_char_fields, clk, rst, record_valid && !run_end,
                   status_code == wqp_pkg::ST_OK && ssid_count == 6'd0 && pass_count == 7'd0,
                   "summary fields on char record")
  `WQP_ASSERT_NEXT(a_full_stalls, clk, rst, qstat.full && !pop, byte_stall, "queue overrun")

endmodule

`default_nettype wire
